/* rtl/sacl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_pkg
// Shared types and codes for the set-associative cache hit and miss unit.
// ----------------------------------------------------------------------------
package sacl_pkg;

  typedef enum logic [1:0] {
    CFG_ADDRESS_BITS = 2'd0,
    CFG_SET_BITS     = 2'd1,
    CFG_OFFSET_BITS  = 2'd2,
    CFG_WAYS_USED    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_LOOKUP = 1'b1
  } state_e;

  localparam int unsigned CfgDataW = 7;

  localparam logic [6:0] AddrBitsRst   = 7'd64;
  localparam logic [2:0] SetBitsRst    = 3'd2;
  localparam logic [5:0] OffsetBitsRst = 6'd4;
  localparam logic [3:0] WaysUsedRst   = 4'd1;

endpackage

/* rtl/sacl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sacl_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module sacl_ram #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 64
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic                                        re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [DATA_W-1:0]                           wdata_i,
  output logic [DATA_W-1:0]                           rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/set_assoc_cache_lru_hit_miss_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_hit_miss_unit
// Set-associative cache directory with per-set LRU replacement and hit and
// miss totals. One set row (tags, ages, valid bits) is held per RAM word.
// ----------------------------------------------------------------------------
// A result passes through the set RAM read register and then the output register.
// A new item is taken only when idle, after the set write-back of the last item.
// A lookup waits while the output register holds a result that is being stalled.
// Reset clears the per-set valid flags and totals and loads the configuration defaults.
// A set never written reads as all lines invalid; no clearing pass is needed.
module set_assoc_cache_lru_hit_miss_unit
  import sacl_pkg::*;
#(
  parameter int unsigned MAX_SET_BITS = 6,
  parameter int unsigned MAX_WAYS     = 8,
  parameter int unsigned ADDR_WIDTH   = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ADDR_WIDTH-1:0] in_address_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  out_hit_o,
  output logic                  out_evicted_o,
  output logic [31:0]           out_hit_total_o,
  output logic [31:0]           out_miss_total_o
);

  localparam int unsigned NumSets = 1 << MAX_SET_BITS;
  localparam int unsigned SetW    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned AgeW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned WayW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NwW     = $clog2(MAX_WAYS + 1);
  localparam int unsigned XW      = (ADDR_WIDTH > SetW) ? ADDR_WIDTH : SetW;
  localparam int unsigned TagsW   = MAX_WAYS * ADDR_WIDTH;
  localparam int unsigned AgesW   = MAX_WAYS * AgeW;
  localparam int unsigned WordW   = TagsW + AgesW + MAX_WAYS;
  localparam logic [AgeW:0] AgeTop = (AgeW + 1)'(MAX_WAYS - 1);

  state_e state_q, state_d;

  logic [6:0] cfg_addr_bits_q;
  logic [2:0] cfg_set_bits_q;
  logic [5:0] cfg_off_bits_q;
  logic [3:0] cfg_ways_q;

  logic [6:0]       ab_c;
  logic [2:0]       sb_c;
  logic [NwW-1:0]   nways;
  logic [6:0]       tag_shift;
  logic [ADDR_WIDTH-1:0] amask;
  logic [SetW-1:0]  rmask;
  logic [ADDR_WIDTH-1:0] masked_in;
  logic [XW-1:0]    sh_in;
  logic [SetW-1:0]  row_in;

  logic                  accept;
  logic                  done;
  logic [ADDR_WIDTH-1:0] addr_q;
  logic [SetW-1:0]       row_q;
  logic [NumSets-1:0]    row_init_q;

  logic [WordW-1:0] ram_rdata;
  logic [WordW-1:0] ram_wdata;
  logic [SetW-1:0]  ram_addr;

  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] tags_r, tags_w;
  logic [MAX_WAYS-1:0][AgeW-1:0]       ages_r, ages_w;
  logic [MAX_WAYS-1:0]                 valid_r, valid_w;
  logic [MAX_WAYS-1:0]                 way_en;
  logic [ADDR_WIDTH-1:0]               tag_cur;

  logic            hit, has_inv;
  logic [WayW-1:0] hit_way, inv_way, vic_way, tgt_way;
  logic [AgeW-1:0] vic_age;
  logic [AgeW:0]   old_age;

  logic        out_valid_q;
  logic        out_hit_q, out_evicted_q;
  logic [31:0] hit_cnt_q, miss_cnt_q;

  // Configuration clamping and address slicing.
  always_comb begin
    ab_c = cfg_addr_bits_q;
    if (cfg_addr_bits_q == 7'd0) begin
      ab_c = 7'd1;
    end else if (cfg_addr_bits_q > 7'd64) begin
      ab_c = 7'd64;
    end
    sb_c = (int'(cfg_set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : cfg_set_bits_q;
    if (cfg_ways_q == 4'd0) begin
      nways = NwW'(1);
    end else if (int'(cfg_ways_q) > MAX_WAYS) begin
      nways = NwW'(MAX_WAYS);
    end else begin
      nways = NwW'(cfg_ways_q);
    end
    tag_shift = 7'(sb_c) + 7'(cfg_off_bits_q);
    amask     = ~({ADDR_WIDTH{1'b1}} << ab_c);
    rmask     = ~({SetW{1'b1}} << sb_c);
    masked_in = in_address_i & amask;
    sh_in     = XW'(masked_in) >> cfg_off_bits_q;
    row_in    = sh_in[SetW-1:0] & rmask;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign done       = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall_i);
  assign ram_addr   = accept ? row_in : row_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  sacl_ram #(
    .DATA_W (WordW),
    .DEPTH  (NumSets)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (done),
    .re_i    (accept),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Search the set, pick the target way and age the others.
  always_comb begin
    tags_r  = ram_rdata[WordW-1 -: TagsW];
    ages_r  = row_init_q[row_q] ? ram_rdata[MAX_WAYS +: AgesW] : '0;
    valid_r = row_init_q[row_q] ? ram_rdata[MAX_WAYS-1:0] : '0;
    tag_cur = addr_q >> tag_shift;

    hit     = 1'b0;
    has_inv = 1'b0;
    hit_way = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      way_en[w] = (w < int'(nways));
      if (way_en[w] && valid_r[w] && (tags_r[w] == tag_cur)) begin
        hit     = 1'b1;
        hit_way = WayW'(w);
      end
      if (way_en[w] && !valid_r[w]) begin
        has_inv = 1'b1;
        inv_way = WayW'(w);
      end
    end

    vic_way = '0;
    vic_age = ages_r[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (way_en[w] && (ages_r[w] > vic_age)) begin
        vic_way = WayW'(w);
        vic_age = ages_r[w];
      end
    end

    if (hit) begin
      tgt_way = hit_way;
      old_age = {1'b0, ages_r[hit_way]};
    end else if (has_inv) begin
      tgt_way = inv_way;
      old_age = AgeTop + (AgeW + 1)'(1);
    end else begin
      tgt_way = vic_way;
      old_age = {1'b0, vic_age};
    end

    tags_w  = tags_r;
    ages_w  = ages_r;
    valid_w = valid_r;
    for (int k = 0; k < MAX_WAYS; k++) begin
      if (way_en[k] && (k != int'(tgt_way)) && valid_r[k] &&
          ({1'b0, ages_r[k]} < old_age) && ({1'b0, ages_r[k]} < AgeTop)) begin
        ages_w[k] = ages_r[k] + AgeW'(1);
      end
    end
    ages_w[tgt_way]  = '0;
    valid_w[tgt_way] = 1'b1;
    if (!hit) begin
      tags_w[tgt_way] = tag_cur;
    end

    ram_wdata = {tags_w, ages_w, valid_w};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      cfg_addr_bits_q <= AddrBitsRst;
      cfg_set_bits_q  <= SetBitsRst;
      cfg_off_bits_q  <= OffsetBitsRst;
      cfg_ways_q      <= WaysUsedRst;
      row_init_q      <= '0;
      out_valid_q     <= 1'b0;
      hit_cnt_q       <= '0;
      miss_cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_ADDRESS_BITS: cfg_addr_bits_q <= cfg_wdata_i;
          CFG_SET_BITS:     cfg_set_bits_q  <= cfg_wdata_i[2:0];
          CFG_OFFSET_BITS:  cfg_off_bits_q  <= cfg_wdata_i[5:0];
          CFG_WAYS_USED:    cfg_ways_q      <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (done) begin
        row_init_q[row_q] <= 1'b1;
        out_valid_q       <= 1'b1;
        if (hit) begin
          if (hit_cnt_q != '1) begin
            hit_cnt_q <= hit_cnt_q + 32'd1;
          end
        end else begin
          if (miss_cnt_q != '1) begin
            miss_cnt_q <= miss_cnt_q + 32'd1;
          end
        end
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= masked_in;
      row_q  <= row_in;
    end
    if (done) begin
      out_hit_q     <= hit;
      out_evicted_q <= !hit && !has_inv;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_hit_o        = out_hit_q;
  assign out_evicted_o    = out_evicted_q;
  assign out_hit_total_o  = hit_cnt_q;
  assign out_miss_total_o = miss_cnt_q;

endmodule
